[design/kmpm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmpm_pkg
// Shared types, defaults and the control store of the KMP stream matcher.
// ----------------------------------------------------------------------------
package kmpm_pkg;

  localparam int unsigned PatternMaxDef   = 32;
  localparam int unsigned PositionBitsDef = 32;
  localparam int unsigned OutW            = 32;
  localparam int unsigned StepW           = 5;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    A_NOP,
    A_LOAD,       // store a pattern byte, count it
    A_FIN,        // close the pattern, start the table build
    A_RD_PI,      // read pattern[i]
    A_RD_PK,      // hold pattern[i] in the byte register, read pattern[k]
    A_RD_FK1,     // read failure[k-1]
    A_K_FROM_F,   // k takes failure data, read pattern[new k]
    A_BSTEP,      // extend or keep k, write failure[i], advance i
    A_CLRK,       // drop k at the end of the build
    A_TNORM,      // bound the progress, read pattern[progress]
    A_TSTEP,      // extend progress, read failure[len-1]
    A_MATCH,      // take a hit: fall back, count it
    A_EMIT        // load the result register, advance position
  } act_e;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_IS_TEXT,
    C_NOT_LAST,
    C_I_LT_M,
    C_NO_FALLBACK,
    C_INACTIVE,
    C_NO_HIT
  } cond_e;

  typedef logic [StepW-1:0] step_t;

  localparam step_t S_IDLE   = 5'd0;
  localparam step_t S_DISP   = 5'd1;
  localparam step_t S_LOAD   = 5'd2;
  localparam step_t S_FIN    = 5'd3;
  localparam step_t S_B0     = 5'd4;
  localparam step_t S_BEND   = 5'd5;
  localparam step_t S_B1     = 5'd6;
  localparam step_t S_B2     = 5'd7;
  localparam step_t S_B3     = 5'd8;
  localparam step_t S_B3B    = 5'd9;
  localparam step_t S_B4     = 5'd10;
  localparam step_t S_TXT    = 5'd11;
  localparam step_t S_T0     = 5'd12;
  localparam step_t S_T1     = 5'd13;
  localparam step_t S_T2     = 5'd14;
  localparam step_t S_T2B    = 5'd15;
  localparam step_t S_T3     = 5'd16;
  localparam step_t S_TMATCH = 5'd17;
  localparam step_t S_TOUT   = 5'd18;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t target;
    logic  in_ready;
    logic  wait_out;
  } uword_t;

  typedef struct packed {
    act_e act;
    logic in_ready;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic is_text;
    logic last;
    logic i_lt_m;
    logic fallback;
    logic inactive;
    logic no_hit;
    logic out_busy;
  } stat_t;

  function automatic uword_t uw(act_e a, cond_e c, step_t t, logic rdy, logic wt);
    uword_t w;
    w.act      = a;
    w.cond     = c;
    w.target   = t;
    w.in_ready = rdy;
    w.wait_out = wt;
    return w;
  endfunction

  // Control store: on a taken condition jump to target, else fall through
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      S_IDLE:   w = uw(A_NOP,      C_NO_ACCEPT,   S_IDLE, 1'b1, 1'b0);
      S_DISP:   w = uw(A_NOP,      C_IS_TEXT,     S_TXT,  1'b0, 1'b0);
      S_LOAD:   w = uw(A_LOAD,     C_NOT_LAST,    S_IDLE, 1'b0, 1'b0);
      S_FIN:    w = uw(A_FIN,      C_NONE,        S_IDLE, 1'b0, 1'b0);
      S_B0:     w = uw(A_RD_PI,    C_I_LT_M,      S_B1,   1'b0, 1'b0);
      S_BEND:   w = uw(A_CLRK,     C_ALWAYS,      S_IDLE, 1'b0, 1'b0);
      S_B1:     w = uw(A_RD_PK,    C_NONE,        S_IDLE, 1'b0, 1'b0);
      S_B2:     w = uw(A_NOP,      C_NO_FALLBACK, S_B4,   1'b0, 1'b0);
      S_B3:     w = uw(A_RD_FK1,   C_NONE,        S_IDLE, 1'b0, 1'b0);
      S_B3B:    w = uw(A_K_FROM_F, C_ALWAYS,      S_B2,   1'b0, 1'b0);
      S_B4:     w = uw(A_BSTEP,    C_ALWAYS,      S_B0,   1'b0, 1'b0);
      S_TXT:    w = uw(A_NOP,      C_INACTIVE,    S_TOUT, 1'b0, 1'b0);
      S_T0:     w = uw(A_TNORM,    C_NONE,        S_IDLE, 1'b0, 1'b0);
      S_T1:     w = uw(A_NOP,      C_NO_FALLBACK, S_T3,   1'b0, 1'b0);
      S_T2:     w = uw(A_RD_FK1,   C_NONE,        S_IDLE, 1'b0, 1'b0);
      S_T2B:    w = uw(A_K_FROM_F, C_ALWAYS,      S_T1,   1'b0, 1'b0);
      S_T3:     w = uw(A_TSTEP,    C_NO_HIT,      S_TOUT, 1'b0, 1'b0);
      S_TMATCH: w = uw(A_MATCH,    C_NONE,        S_IDLE, 1'b0, 1'b0);
      S_TOUT:   w = uw(A_EMIT,     C_ALWAYS,      S_IDLE, 1'b0, 1'b1);
      default:  w = uw(A_NOP,      C_ALWAYS,      S_IDLE, 1'b0, 1'b0);
    endcase
    return w;
  endfunction

endpackage

[design/kmpm_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmpm_req_if
// Request channel: one pattern or text byte per request.
// ----------------------------------------------------------------------------
interface kmpm_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output cmd, output data_byte, output last, input ready);
  modport sink   (input valid, input cmd, input data_byte, input last, output ready);
endinterface

[design/kmpm_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmpm_res_if
// Result channel: one result per text byte.
// ----------------------------------------------------------------------------
interface kmpm_res_if;
  logic        valid;
  logic        ready;
  logic        match_found;
  logic [31:0] match_start;
  logic [31:0] match_count;
  logic        no_pattern;

  modport source (output valid, output match_found, output match_start,
                  output match_count, output no_pattern, input ready);
  modport sink   (input valid, input match_found, input match_start,
                  input match_count, input no_pattern, output ready);
endinterface

[design/kmpm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/kmpm_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmpm_seq
// Step counter and control store walk with conditional jumps.
// ----------------------------------------------------------------------------
module kmpm_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kmpm_pkg::stat_t  stat_i,
  output kmpm_pkg::ctrl_t  ctrl_o
);

  kmpm_pkg::step_t  upc_q, upc_d;
  kmpm_pkg::uword_t word;
  logic             take;
  logic             stall;

  always_comb begin
    word  = kmpm_pkg::ucode(upc_q);
    // hold the emit step while the result register is still full
    stall = word.wait_out && stat_i.out_busy;
    case (word.cond)
      kmpm_pkg::C_NONE:        take = 1'b0;
      kmpm_pkg::C_ALWAYS:      take = 1'b1;
      kmpm_pkg::C_NO_ACCEPT:   take = !stat_i.accept;
      kmpm_pkg::C_IS_TEXT:     take = stat_i.is_text;
      kmpm_pkg::C_NOT_LAST:    take = !stat_i.last;
      kmpm_pkg::C_I_LT_M:      take = stat_i.i_lt_m;
      kmpm_pkg::C_NO_FALLBACK: take = !stat_i.fallback;
      kmpm_pkg::C_INACTIVE:    take = stat_i.inactive;
      kmpm_pkg::C_NO_HIT:      take = stat_i.no_hit;
      default:                 take = 1'b0;
    endcase
    if (stall) begin
      upc_d = upc_q;
    end else if (take) begin
      upc_d = word.target;
    end else begin
      upc_d = kmpm_pkg::step_t'(upc_q + 1'b1);
    end
    ctrl_o.act      = stall ? kmpm_pkg::A_NOP : word.act;
    ctrl_o.in_ready = word.in_ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= kmpm_pkg::S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

[design/kmpm_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmpm_dp
// Matcher datapath: pattern and failure RAMs, index registers, result register.
// ----------------------------------------------------------------------------
module kmpm_dp #(
  parameter int unsigned PatternMax   = kmpm_pkg::PatternMaxDef,
  parameter int unsigned PositionBits = kmpm_pkg::PositionBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kmpm_pkg::ctrl_t ctrl_i,
  output kmpm_pkg::stat_t stat_o,
  kmpm_req_if.sink        req_i,
  kmpm_res_if.source      res_o,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i
);

  localparam int unsigned AW = (PatternMax > 1) ? $clog2(PatternMax) : 1;
  localparam int unsigned LW = $clog2(PatternMax + 2);
  localparam int unsigned PW = PositionBits;
  localparam int unsigned OW = kmpm_pkg::OutW;
  localparam int unsigned SW = (PW > OW) ? PW : OW;

  logic          cmd_q, cmd_d, last_q, last_d;
  logic [7:0]    c_q, c_d;
  logic [LW-1:0] k_q, k_d, i_q, i_d, len_q, len_d, load_q, load_d;
  logic          bad_q, bad_d, ff_q, ff_d, found_q, found_d, fonly_q, fonly_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [OW-1:0] cnt_q, cnt_d;

  logic          ov_q, ov_d, of_q, of_d, onp_q, onp_d;
  logic [OW-1:0] ostart_q, ostart_d, ocnt_q, ocnt_d;

  logic          p_we, p_re, f_we, f_re;
  logic [AW-1:0] p_waddr, p_raddr, f_waddr, f_raddr;
  logic [7:0]    p_wdata, p_rdata;
  logic [LW-1:0] f_wdata, f_rdata;

  logic          accept, eq;
  logic [LW-1:0] kn, km1, lm1, knorm;
  logic [SW-1:0] pos_w, m1_w, start_w;
  logic [OW-1:0] start32;

  kmpm_ram #(.Width(8), .Depth(PatternMax)) u_pat_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(p_wdata),
    .re_i   (p_re),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  kmpm_ram #(.Width(LW), .Depth(PatternMax)) u_fail_ram (
    .clk_i  (clk_i),
    .we_i   (f_we),
    .waddr_i(f_waddr),
    .wdata_i(f_wdata),
    .re_i   (f_re),
    .raddr_i(f_raddr),
    .rdata_o(f_rdata)
  );

  assign accept      = req_i.valid && ctrl_i.in_ready;
  assign req_i.ready = ctrl_i.in_ready;

  assign eq    = (c_q == p_rdata);
  assign kn    = k_q + LW'(eq);
  assign km1   = k_q - 1'b1;
  assign lm1   = len_q - 1'b1;
  assign knorm = (k_q >= len_q) ? '0 : k_q;

  // start offset of a hit, clamped to the result width
  assign pos_w   = SW'(pos_q);
  assign m1_w    = SW'(lm1);
  assign start_w = (pos_w >= m1_w) ? (pos_w - m1_w) : '0;
  assign start32 = (start_w > SW'({OW{1'b1}})) ? {OW{1'b1}} : start_w[OW-1:0];

  always_comb begin
    stat_o.accept   = accept;
    stat_o.is_text  = cmd_q;
    stat_o.last     = last_q;
    stat_o.i_lt_m   = (i_q < len_q);
    stat_o.fallback = (k_q != '0) && !eq;
    stat_o.inactive = (len_q == '0) || bad_q || (fonly_q && ff_q);
    stat_o.no_hit   = (kn != len_q);
    stat_o.out_busy = ov_q && !res_o.ready;
  end

  always_comb begin
    cmd_d    = cmd_q;
    last_d   = last_q;
    c_d      = c_q;
    k_d      = k_q;
    i_d      = i_q;
    len_d    = len_q;
    load_d   = load_q;
    bad_d    = bad_q;
    ff_d     = ff_q;
    found_d  = found_q;
    fonly_d  = fonly_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    ov_d     = ov_q && !res_o.ready;
    of_d     = of_q;
    onp_d    = onp_q;
    ostart_d = ostart_q;
    ocnt_d   = ocnt_q;
    p_we     = 1'b0;
    p_waddr  = load_q[AW-1:0];
    p_wdata  = c_q;
    p_re     = 1'b0;
    p_raddr  = i_q[AW-1:0];
    f_we     = 1'b0;
    f_waddr  = i_q[AW-1:0];
    f_wdata  = kn;
    f_re     = 1'b0;
    f_raddr  = km1[AW-1:0];

    if (accept) begin
      cmd_d  = req_i.cmd;
      c_d    = req_i.data_byte;
      last_d = req_i.last;
    end
    if (cfg_we_i) begin
      fonly_d = cfg_wdata_i;
    end

    case (ctrl_i.act)
      kmpm_pkg::A_LOAD: begin
        if (load_q == '0) begin
          len_d = '0;
        end
        if (load_q < LW'(PatternMax)) begin
          p_we = 1'b1;
        end
        if (load_q <= LW'(PatternMax)) begin
          load_d = load_q + 1'b1;
        end
      end
      kmpm_pkg::A_FIN: begin
        if (load_q > LW'(PatternMax)) begin
          bad_d = 1'b1;
          len_d = '0;
        end else begin
          bad_d = 1'b0;
          len_d = load_q;
        end
        load_d  = '0;
        k_d     = '0;
        i_d     = LW'(1);
        pos_d   = '0;
        cnt_d   = '0;
        ff_d    = 1'b0;
        f_we    = 1'b1;
        f_waddr = '0;
        f_wdata = '0;
      end
      kmpm_pkg::A_RD_PI: begin
        p_re = 1'b1;
      end
      kmpm_pkg::A_RD_PK: begin
        c_d     = p_rdata;
        p_re    = 1'b1;
        p_raddr = k_q[AW-1:0];
      end
      kmpm_pkg::A_RD_FK1: begin
        f_re = 1'b1;
      end
      kmpm_pkg::A_K_FROM_F: begin
        k_d     = f_rdata;
        p_re    = 1'b1;
        p_raddr = f_rdata[AW-1:0];
      end
      kmpm_pkg::A_BSTEP: begin
        k_d  = kn;
        f_we = 1'b1;
        i_d  = i_q + 1'b1;
      end
      kmpm_pkg::A_CLRK: begin
        k_d = '0;
      end
      kmpm_pkg::A_TNORM: begin
        k_d     = knorm;
        p_re    = 1'b1;
        p_raddr = knorm[AW-1:0];
      end
      kmpm_pkg::A_TSTEP: begin
        k_d     = kn;
        f_re    = 1'b1;
        f_raddr = lm1[AW-1:0];
      end
      kmpm_pkg::A_MATCH: begin
        k_d     = f_rdata;
        found_d = 1'b1;
        ff_d    = 1'b1;
        if (cnt_q != {OW{1'b1}}) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      kmpm_pkg::A_EMIT: begin
        ov_d     = 1'b1;
        of_d     = found_q;
        ostart_d = found_q ? start32 : '0;
        ocnt_d   = cnt_q;
        onp_d    = bad_q || (len_q == '0);
        found_d  = 1'b0;
        if (pos_q != {PW{1'b1}}) begin
          pos_d = pos_q + 1'b1;
        end
        if (last_q) begin
          k_d   = '0;
          pos_d = '0;
          cnt_d = '0;
          ff_d  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      i_q     <= '0;
      len_q   <= '0;
      load_q  <= '0;
      bad_q   <= 1'b0;
      ff_q    <= 1'b0;
      found_q <= 1'b0;
      fonly_q <= 1'b0;
      pos_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      k_q     <= k_d;
      i_q     <= i_d;
      len_q   <= len_d;
      load_q  <= load_d;
      bad_q   <= bad_d;
      ff_q    <= ff_d;
      found_q <= found_d;
      fonly_q <= fonly_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    last_q   <= last_d;
    c_q      <= c_d;
    of_q     <= of_d;
    onp_q    <= onp_d;
    ostart_q <= ostart_d;
    ocnt_q   <= ocnt_d;
  end

  assign res_o.valid       = ov_q;
  assign res_o.match_found = of_q;
  assign res_o.match_start = ostart_q;
  assign res_o.match_count = ocnt_q;
  assign res_o.no_pattern  = onp_q;

endmodule

[design/kmp_stream_matcher_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_stream_matcher_core
// Knuth-Morris-Pratt byte stream matcher driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Sequence: a text byte passes dispatch, the progress bound, each fallback step
//   through the failure table, the extend step and, on a hit, the fall-back step,
//   then emit; with no usable pattern or a frozen first-only text it goes to emit.
// Requests: one at a time; the next is taken only back in the idle step. A pattern
//   byte is stored and counted; the last one also runs the table build.
// Reset: async, active low; clears sequencer, counters and pattern length.
//   Pattern and failure RAMs are not cleared; only written entries are used.
// ----------------------------------------------------------------------------
module kmp_stream_matcher_core #(
  parameter int unsigned PatternMax   = kmpm_pkg::PatternMaxDef,
  parameter int unsigned PositionBits = kmpm_pkg::PositionBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kmpm_req_if.sink   req_i,
  kmpm_res_if.source res_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  // Sequencer status and control words
  kmpm_pkg::ctrl_t ctrl;
  kmpm_pkg::stat_t stat;

  // Walk the control store: each step issues one datapath operation and
  // either falls through or jumps on a datapath condition. The emit step
  // holds while the previous result has not been taken.
  kmpm_seq u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .ctrl_o(ctrl)
  );

  // Datapath: pattern RAM, failure RAM (one read port each, registered),
  // match progress / build index registers, position and count counters,
  // and the result register that parts the request and result sides.
  kmpm_dp #(
    .PatternMax  (PatternMax),
    .PositionBits(PositionBits)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .req_i      (req_i),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

endmodule

[design/kmpm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmpm_checker
// Port-level checks of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
module kmpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        req_cmd_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        res_match_found_i,
  input logic [31:0] res_match_start_i,
  input logic [31:0] res_match_count_i,
  input logic        res_no_pattern_i
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_match_found_i) &&
      $stable(res_match_start_i) && $stable(res_match_count_i) &&
      $stable(res_no_pattern_i))
    else $error("result changed while stalled");

  // one request at a time: busy right after a request is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // a pattern byte produces no result
  a_pattern_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && !req_cmd_i && !res_valid_i |=> !res_valid_i)
    else $error("result from pattern byte");

  // a hit needs a usable pattern and is counted
  a_hit_usable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_match_found_i |-> !res_no_pattern_i &&
      res_match_count_i != 32'd0)
    else $error("hit without pattern or count");

endmodule

bind kmp_stream_matcher_core kmpm_checker u_kmpm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .req_cmd_i        (req_i.cmd),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_match_found_i(res_o.match_found),
  .res_match_start_i(res_o.match_start),
  .res_match_count_i(res_o.match_count),
  .res_no_pattern_i (res_o.no_pattern)
);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the KMP stream matcher core. A behavioral matcher
// predicts the result of every accepted text request; a monitor compares
// each result, in order, under random gaps on the request side and random
// stalls on the result side. Directed cases come first, then random patterns
// and texts under three idling mixes.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned PatMax = kmpm_pkg::PatternMaxDef;

  // Request kinds on the cmd field
  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  // A full table build over the longest pattern, with fallback steps, stays
  // well below this; used before register writes and at the end of the run.
  localparam int unsigned SettleCycles = 400;

  typedef struct packed {
    logic        found;
    logic [31:0] start;
    logic [31:0] count;
    logic        no_pat;
  } match_result_t;

  typedef logic [7:0] byte_q_t[$];

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  kmpm_req_if req_if ();
  kmpm_res_if res_if ();

  kmp_stream_matcher_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Matcher state of the predictor
  logic [7:0]  pat_mem [PatMax];
  logic [5:0]  fail_tbl [PatMax];
  int unsigned pat_len;
  int unsigned load_cnt;
  int unsigned prog;
  logic        pat_bad;
  logic        hit_seen;
  logic        first_only_q;
  logic [31:0] text_pos;
  logic [31:0] hit_count;

  // Results still owed by the block, oldest first
  match_result_t expected_results[$];

  int unsigned req_count;
  int unsigned err_count;
  int unsigned req_gap_pct;
  int unsigned res_stall_pct;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : run_limit
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Drop position, count and progress at the start of a new text.
  function automatic void clear_text_state();
    prog      = 0;
    text_pos  = '0;
    hit_count = '0;
    hit_seen  = 1'b0;
  endfunction

  // Build the prefix-failure table over the first m pattern bytes.
  function automatic void build_fail_table(int unsigned m);
    int unsigned k;
    k = 0;
    fail_tbl[0] = '0;
    for (int unsigned i = 1; i < m; i++) begin
      while (k > 0 && pat_mem[i] != pat_mem[k]) k = fail_tbl[k-1];
      if (pat_mem[i] == pat_mem[k]) k++;
      fail_tbl[i] = 6'(k);
    end
  endfunction

  // Advance the predictor by one accepted request; queue a result for text.
  function automatic void predict_request(logic cmd, logic [7:0] b, logic lst);
    match_result_t r;
    int unsigned   j;
    r = '0;
    if (cmd == CMD_PATTERN) begin
      // The first byte of a new pattern empties the current one.
      if (load_cnt == 0) pat_len = 0;
      if (load_cnt < PatMax) pat_mem[load_cnt] = b;
      // Saturate one past capacity so an over-long pattern is recognized.
      if (load_cnt <= PatMax) load_cnt++;
      if (lst) begin
        if (load_cnt > PatMax) begin
          pat_bad = 1'b1;
          pat_len = 0;
        end else begin
          pat_bad = 1'b0;
          pat_len = load_cnt;
          build_fail_table(load_cnt);
        end
        load_cnt = 0;
        clear_text_state();
      end
      return;
    end
    // Freeze the matcher once first-only mode has seen its hit.
    if (pat_len > 0 && !pat_bad && !(first_only_q && hit_seen)) begin
      j = (prog >= pat_len) ? 0 : prog;
      while (j > 0 && b != pat_mem[j]) j = fail_tbl[j-1];
      if (b == pat_mem[j]) j++;
      if (j == pat_len) begin
        r.found = 1'b1;
        r.start = (text_pos >= pat_len - 1) ? text_pos - (pat_len - 1) : '0;
        // Fall back so overlapping occurrences are still found.
        j = fail_tbl[pat_len-1];
        if (hit_count != '1) hit_count++;
        hit_seen = 1'b1;
      end
      prog = j;
    end
    if (text_pos != '1) text_pos++;
    r.count  = hit_count;
    r.no_pat = pat_bad || (pat_len == 0);
    expected_results.insert(expected_results.size(), r);
    if (lst) clear_text_state();
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one request, with a random gap first; hold valid high afterwards so
  // back-to-back requests need no extra edge.
  task automatic send_request(logic cmd, logic [7:0] b, logic lst);
    if ($urandom_range(99) < req_gap_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < req_gap_pct);
    end
    req_if.valid     <= 1'b1;
    req_if.cmd       <= cmd;
    req_if.data_byte <= b;
    req_if.last      <= lst;
    do @(posedge clk_i); while (!req_if.ready);
    predict_request(cmd, b, lst);
    req_count++;
  endtask

  // Drop valid, wait for every owed result, then let a table build finish.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the first-only register while the block is idle.
  task automatic write_first_only(logic v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    first_only_q = v;
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_pattern(byte_q_t pat);
    foreach (pat[i]) send_request(CMD_PATTERN, pat[i], i == pat.size() - 1);
  endtask

  // Send one text over a small alphabet, with copies of the pattern spliced
  // in now and then so hits and overlaps are frequent.
  task automatic send_text(int unsigned len, logic [7:0] base, int unsigned alph,
                           byte_q_t pat);
    byte_q_t txt;
    while (txt.size() < len) begin
      if (pat.size() > 0 && $urandom_range(5) == 0) begin
        foreach (pat[i]) txt.insert(txt.size(), pat[i]);
      end else begin
        txt.insert(txt.size(), base + 8'($urandom_range(alph - 1)));
      end
    end
    foreach (txt[i]) send_request(CMD_TEXT, txt[i], i == txt.size() - 1);
  endtask

  // --------------------------------------------------------------------------
  // Result side: compare each accepted result with the oldest expectation
  // --------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  initial begin : result_check
    match_result_t exp_r;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid === 1'b1 && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: match_found %0b match_count %0d",
                 res_if.match_found, res_if.match_count);
          err_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("match_found", 32'(exp_r.found), 32'(res_if.match_found));
          check_field("match_start", exp_r.start, res_if.match_start);
          check_field("match_count", exp_r.count, res_if.match_count);
          check_field("no_pattern", 32'(exp_r.no_pat), 32'(res_if.no_pattern));
        end
      end
      // Stall the result side at random; hold ready high when stalls are off.
      res_if.ready <= ($urandom_range(99) >= res_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Feed text before any pattern exists: no hit, no_pattern set.
  task automatic test_no_pattern();
    send_request(CMD_TEXT, 8'h5A, 1'b0);
    send_request(CMD_TEXT, 8'hA5, 1'b0);
    send_request(CMD_TEXT, 8'h3C, 1'b1);
  endtask

  // Use the extreme byte values as pattern and text; then check overlapping
  // hits through the failure table on a repeated-byte pattern.
  task automatic test_byte_extremes_and_overlap();
    send_request(CMD_PATTERN, 8'h00, 1'b0);
    send_request(CMD_PATTERN, 8'hFF, 1'b1);
    send_request(CMD_TEXT, 8'h00, 1'b0);
    send_request(CMD_TEXT, 8'hFF, 1'b0);
    send_request(CMD_TEXT, 8'h00, 1'b0);
    send_request(CMD_TEXT, 8'hFF, 1'b1);
    send_request(CMD_PATTERN, 8'h61, 1'b0);
    send_request(CMD_PATTERN, 8'h61, 1'b1);
    repeat (4) send_request(CMD_TEXT, 8'h61, 1'b0);
    send_request(CMD_TEXT, 8'h61, 1'b1);
  endtask

  // Stop after the first hit of a text, then restore the default mode.
  task automatic test_first_only();
    write_first_only(1'b1);
    send_request(CMD_TEXT, 8'h61, 1'b0);
    send_request(CMD_TEXT, 8'h61, 1'b0);
    send_request(CMD_TEXT, 8'h61, 1'b1);
    write_first_only(1'b0);
  endtask

  // Text arriving while a pattern is half loaded sees no usable pattern.
  task automatic test_load_interrupt();
    send_request(CMD_PATTERN, 8'h71, 1'b0);
    send_request(CMD_TEXT, 8'h71, 1'b1);
    send_request(CMD_PATTERN, 8'h72, 1'b1);
    send_request(CMD_TEXT, 8'h71, 1'b0);
    send_request(CMD_TEXT, 8'h72, 1'b1);
  endtask

  // Random sessions: mostly a well-formed pattern followed by matching texts,
  // the rest over-long patterns, interrupted loads and raw noise.
  task automatic test_random_search(int unsigned n_items, int unsigned gap_pct,
                                    int unsigned stall_pct);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned alph;
    int unsigned len;
    logic [7:0]  base;
    byte_q_t     pat;
    byte_q_t     none;
    req_gap_pct   = gap_pct;
    res_stall_pct = stall_pct;
    stop_at = req_count + n_items;
    while (req_count < stop_at) begin
      if ($urandom_range(4) == 0) write_first_only(1'($urandom_range(1)));
      kind = $urandom_range(99);
      base = 8'($urandom_range(255));
      alph = $urandom_range(3, 1);
      pat.delete();
      if (kind < 75) begin
        // Well-formed: pattern, then a few texts; now and then full capacity.
        if ($urandom_range(15) == 0) begin
          len  = PatMax;
          alph = $urandom_range(2, 1);
        end else begin
          len = $urandom_range(6, 1);
        end
        repeat (len) pat.insert(pat.size(), base + 8'($urandom_range(alph - 1)));
        load_pattern(pat);
        repeat ($urandom_range(3, 1)) send_text($urandom_range(30, 4), base, alph, pat);
      end else if (kind < 85) begin
        // Over-long pattern: dropped bytes, then text sees no pattern.
        repeat ($urandom_range(PatMax + 4, PatMax + 1))
          pat.insert(pat.size(), base + 8'($urandom_range(alph - 1)));
        load_pattern(pat);
        send_text($urandom_range(12, 4), base, alph, none);
      end else if (kind < 93) begin
        // Interrupted load: text slips in before the pattern is closed.
        repeat ($urandom_range(4, 1))
          send_request(CMD_PATTERN, base + 8'($urandom_range(alph - 1)), 1'b0);
        repeat ($urandom_range(3, 1))
          send_request(CMD_TEXT, 8'($urandom_range(255)), 1'($urandom_range(1)));
        send_request(CMD_PATTERN, base + 8'($urandom_range(alph - 1)), 1'b1);
        send_text($urandom_range(16, 4), base, alph, none);
      end else begin
        // Raw noise: any kind, any byte, last set now and then.
        repeat ($urandom_range(16, 4))
          send_request(1'($urandom_range(1)), 8'($urandom_range(255)),
                       $urandom_range(4) == 0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    // Drive every input to a known value and hold reset.
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = 1'b0;
    req_if.valid     = 1'b0;
    req_if.cmd       = CMD_PATTERN;
    req_if.data_byte = '0;
    req_if.last      = 1'b0;
    pat_len          = 0;
    load_cnt         = 0;
    pat_bad          = 1'b0;
    first_only_q     = 1'b0;
    req_count        = 0;
    err_count        = 0;
    req_gap_pct      = 34;
    res_stall_pct    = 46;
    clear_text_state();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Write the register once up front at its reset value.
    write_first_only(1'b0);

    test_no_pattern();
    test_byte_extremes_and_overlap();
    test_first_only();
    test_load_interrupt();

    // Sender idles less than receiver, then the reverse, then no idling.
    test_random_search(642, 34, 46);
    test_random_search(642, 46, 34);
    test_random_search(642, 0, 0);

    // Wait for the last results and let any trailing build settle.
    wait_idle();
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
